// ----- rtl/core/sdbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// sdbcm_pkg: shared types and constants of the dB to colormap pipeline
// Color stop table, per-segment spans and reciprocals, shaping curve function.
// ----------------------------------------------------------------------------
package sdbcm_pkg;

  localparam int unsigned DEF_SHAPE_TABLE_BITS = 10;
  localparam int unsigned DEF_RATIO_FRAC_BITS  = 16;

  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SHAPED_W   = 17;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned CHAN_IDX_W = 2;
  localparam int unsigned NUM_SEGS   = 7;
  localparam int unsigned SEG_W      = 3;
  localparam int unsigned SPAN_W     = 14;
  localparam int unsigned RECIP_W    = 20;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned PROD_W     = CHAN_W + SPAN_W;
  localparam int unsigned SCALE_W    = PROD_W + RECIP_W;
  localparam int unsigned REM_W      = SPAN_W + 1;

  localparam logic [SHAPED_W-1:0] SHAPED_ONE = {1'b1, {(SHAPED_W-1){1'b0}}};
  localparam real SHAPE_EXP = 39.0 / 50.0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } cfg_reg_e;

  localparam logic signed [LEVEL_W-1:0] FLOOR_RESET   = -16'sd30720;
  localparam logic signed [LEVEL_W-1:0] CEILING_RESET = 16'sd0;

  // stop positions on the shaped axis, 1.0 = 65536
  localparam logic [SHAPED_W-1:0] STOP_POS [NUM_SEGS+1] = '{
    17'd0, 17'd7864, 17'd18350, 17'd29491, 17'd40632, 17'd51118, 17'd58982, 17'd65536
  };

  localparam logic [CHAN_W-1:0] STOP_RGB [NUM_SEGS+1][NUM_CHAN] = '{
    '{8'd2,   8'd4,   8'd10},
    '{8'd8,   8'd18,  8'd46},
    '{8'd22,  8'd58,  8'd124},
    '{8'd28,  8'd142, 8'd196},
    '{8'd76,  8'd208, 8'd160},
    '{8'd244, 8'd220, 8'd72},
    '{8'd245, 8'd128, 8'd32},
    '{8'd250, 8'd250, 8'd250}
  };

  // width of each segment between two stops
  localparam logic [SPAN_W-1:0] SEG_SPAN [NUM_SEGS] = '{
    14'd7864, 14'd10486, 14'd11141, 14'd11141, 14'd10486, 14'd7864, 14'd6554
  };

  // floor(2^32 / span), never above the true reciprocal
  localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
    20'd546155, 20'd409590, 20'd385510, 20'd385510, 20'd409590, 20'd546155, 20'd655320
  };

  // true when the channel grows from the lower stop to the upper stop
  function automatic logic seg_rising(logic [SEG_W-1:0] seg, logic [CHAN_IDX_W-1:0] ch);
    return STOP_RGB[SEG_W'(seg + SEG_W'(1))][ch] >= STOP_RGB[seg][ch];
  endfunction

  // falling segments are interpolated from the upper stop downward
  function automatic logic [CHAN_W-1:0] seg_base(logic [SEG_W-1:0] seg,
                                                 logic [CHAN_IDX_W-1:0] ch);
    return seg_rising(seg, ch) ? STOP_RGB[seg][ch] : STOP_RGB[SEG_W'(seg + SEG_W'(1))][ch];
  endfunction

  function automatic logic [CHAN_W-1:0] seg_mag(logic [SEG_W-1:0] seg,
                                                logic [CHAN_IDX_W-1:0] ch);
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] hi;
    lo = STOP_RGB[seg][ch];
    hi = STOP_RGB[SEG_W'(seg + SEG_W'(1))][ch];
    return seg_rising(seg, ch) ? CHAN_W'(hi - lo) : CHAN_W'(lo - hi);
  endfunction

  // shaping curve: floor(65536 * (idx / 2^bits)^0.78), evaluated at elaboration
  function automatic logic [SHAPED_W-1:0] shape_value(int unsigned idx, int unsigned bits);
    real frac;
    real scaled;
    logic [SHAPED_W-1:0] val;
    frac = real'(idx) * (2.0 ** (-1.0 * real'(bits)));
    if (idx == 0) begin
      val = '0;
    end else if (frac >= 1.0) begin
      val = SHAPED_ONE;
    end else begin
      scaled = 65536.0 * (frac ** SHAPE_EXP);
      val = SHAPED_W'($rtoi(scaled));
    end
    return val;
  endfunction

endpackage

// ----- rtl/core/sdbcm_ratio.sv -----
// ----------------------------------------------------------------------------
// sdbcm_ratio: level normalization and ratio divider
// Clamps the level against floor and ceiling, then a restoring divider
// produces one quotient bit per pipeline stage to form the shaping index.
// ----------------------------------------------------------------------------
module sdbcm_ratio import sdbcm_pkg::*; #(
  parameter int unsigned ShapeTableBits = DEF_SHAPE_TABLE_BITS,
  parameter int unsigned RatioFracBits  = DEF_RATIO_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [LEVEL_W-1:0] floor_i,
  input  logic signed [LEVEL_W-1:0] ceiling_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [LEVEL_W-1:0] level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ShapeTableBits:0]   idx_o
);

  // only the quotient bits that reach the index are computed
  localparam int unsigned QuoBits  = (RatioFracBits < ShapeTableBits) ? RatioFracBits
                                                                      : ShapeTableBits;
  localparam int unsigned IdxShift = ShapeTableBits - QuoBits;
  localparam int unsigned IdxW     = ShapeTableBits + 1;
  localparam int unsigned NumStg   = QuoBits + 1;
  localparam logic [IdxW-1:0] IdxFull = {1'b1, {ShapeTableBits{1'b0}}};

  typedef enum logic [1:0] {
    ModeZero = 2'd0,
    ModeFull = 2'd1,
    ModeDiv  = 2'd2
  } ratio_mode_e;

  logic [NumStg-1:0]   vld_q;
  logic [NumStg-1:0]   en;
  ratio_mode_e         mode_q [NumStg];
  logic [LEVEL_W-1:0]  rem_q  [NumStg];
  logic [LEVEL_W-1:0]  den_q  [NumStg];
  logic [QuoBits-1:0]  quo_q  [NumStg];

  logic signed [LEVEL_W:0] diff;
  logic signed [LEVEL_W:0] span;
  ratio_mode_e             mode_d;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int j = NumStg - 2; j >= 0; j--) begin
      en[j] = !vld_q[j] || en[j+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  always_comb begin
    diff = $signed({level_i[LEVEL_W-1], level_i}) - $signed({floor_i[LEVEL_W-1], floor_i});
    span = $signed({ceiling_i[LEVEL_W-1], ceiling_i}) - $signed({floor_i[LEVEL_W-1], floor_i});
    if (span <= 17'sd0) begin
      mode_d = (level_i >= ceiling_i) ? ModeFull : ModeZero;
    end else if (diff <= 17'sd0) begin
      mode_d = ModeZero;
    end else if (diff >= span) begin
      mode_d = ModeFull;
    end else begin
      mode_d = ModeDiv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int j = 1; j < NumStg; j++) begin
        if (en[j]) begin
          vld_q[j] <= vld_q[j-1];
        end
      end
    end
  end

  // 0 < diff < span here whenever the divider result is used
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q[0] <= mode_d;
      rem_q[0]  <= diff[LEVEL_W-1:0];
      den_q[0]  <= span[LEVEL_W-1:0];
      quo_q[0]  <= '0;
    end
  end

  for (genvar j = 1; j < NumStg; j++) begin : g_div
    logic [LEVEL_W:0] trial;
    logic             take;

    assign trial = {rem_q[j-1], 1'b0};
    assign take  = trial >= {1'b0, den_q[j-1]};

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        mode_q[j] <= mode_q[j-1];
        den_q[j]  <= den_q[j-1];
        rem_q[j]  <= take ? LEVEL_W'(trial - {1'b0, den_q[j-1]}) : LEVEL_W'(trial);
        quo_q[j]  <= {quo_q[j-1][QuoBits-2:0], take};
      end
    end
  end

  always_comb begin
    case (mode_q[NumStg-1])
      ModeFull: idx_o = IdxFull;
      ModeDiv:  idx_o = IdxW'(quo_q[NumStg-1]) << IdxShift;
      default:  idx_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/sdbcm_shape.sv -----
// ----------------------------------------------------------------------------
// sdbcm_shape: gamma shaping lookup
// Constant ROM of the 0.78 power curve with a registered read port.
// ----------------------------------------------------------------------------
module sdbcm_shape import sdbcm_pkg::*; #(
  parameter int unsigned ShapeTableBits = DEF_SHAPE_TABLE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ShapeTableBits:0] idx_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SHAPED_W-1:0]     shaped_o
);

  localparam int unsigned RomDepth = (1 << ShapeTableBits) + 1;

  typedef logic [SHAPED_W-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int unsigned i = 0; i < RomDepth; i++) begin
      tbl[i] = shape_value(i, ShapeTableBits);
    end
    return tbl;
  endfunction

  localparam rom_t ShapeRom = build_rom();

  logic                vld_q;
  logic                en;
  logic [SHAPED_W-1:0] shaped_q;

  assign en          = !vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q;
  assign shaped_o    = shaped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      shaped_q <= ShapeRom[idx_i];
    end
  end

endmodule

// ----- rtl/core/sdbcm_interp.sv -----
// ----------------------------------------------------------------------------
// sdbcm_interp: color stop interpolation
// Finds the segment, scales the offset per channel and divides by the segment
// span with a reciprocal multiply and a one-step remainder correction.
// ----------------------------------------------------------------------------
module sdbcm_interp import sdbcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SHAPED_W-1:0] shaped_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAN_W-1:0]   red_o,
  output logic [CHAN_W-1:0]   green_o,
  output logic [CHAN_W-1:0]   blue_o
);

  localparam int unsigned NumStg = 6;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_t;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] en;

  // segment select
  logic [SEG_W-1:0]    seg_d;
  logic [SEG_W-1:0]    seg0_q;
  logic [SHAPED_W-1:0] shp0_q;
  // per-channel operands
  chan_vec_t                       base_d, mag_d;
  logic [NUM_CHAN-1:0][SPAN_W-1:0] mult_d;
  logic [SEG_W-1:0]                seg1_q;
  chan_vec_t                       base1_q, mag1_q;
  logic [NUM_CHAN-1:0][SPAN_W-1:0] mult1_q;
  // offset times color step
  logic [NUM_CHAN-1:0][PROD_W-1:0] prod_d;
  logic [SEG_W-1:0]                seg2_q;
  chan_vec_t                       base2_q;
  logic [NUM_CHAN-1:0][PROD_W-1:0] prod2_q;
  // reciprocal estimate
  logic [NUM_CHAN-1:0][SCALE_W-1:0] scl;
  chan_vec_t                        quo_d;
  logic [SEG_W-1:0]                 seg3_q;
  chan_vec_t                        base3_q, quo3_q;
  logic [NUM_CHAN-1:0][PROD_W-1:0]  prod3_q;
  // remainder
  logic [NUM_CHAN-1:0][PROD_W-1:0]  back;
  logic [NUM_CHAN-1:0][REM_W-1:0]   rem_d;
  logic [SEG_W-1:0]                 seg4_q;
  chan_vec_t                        base4_q, quo4_q;
  logic [NUM_CHAN-1:0][REM_W-1:0]   rem4_q;
  // final channel
  chan_vec_t                        chan_d, chan5_q;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int j = NumStg - 2; j >= 0; j--) begin
      en[j] = !vld_q[j] || en[j+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign red_o       = chan5_q[0];
  assign green_o     = chan5_q[1];
  assign blue_o      = chan5_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int j = 1; j < NumStg; j++) begin
        if (en[j]) begin
          vld_q[j] <= vld_q[j-1];
        end
      end
    end
  end

  // segment below the first stop at or above the shaped value, top segment otherwise
  always_comb begin
    seg_d = SEG_W'(NUM_SEGS - 1);
    for (int s = NUM_SEGS - 2; s >= 0; s--) begin
      if (shaped_i <= STOP_POS[s+1]) begin
        seg_d = SEG_W'(s);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      seg0_q <= seg_d;
      shp0_q <= shaped_i;
    end
  end

  // falling channels measure the distance from the upper stop
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      base_d[c] = seg_base(seg0_q, CHAN_IDX_W'(c));
      mag_d[c]  = seg_mag(seg0_q, CHAN_IDX_W'(c));
      mult_d[c] = seg_rising(seg0_q, CHAN_IDX_W'(c))
                ? SPAN_W'(shp0_q - STOP_POS[seg0_q])
                : SPAN_W'(STOP_POS[SEG_W'(seg0_q + SEG_W'(1))] - shp0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      seg1_q  <= seg0_q;
      base1_q <= base_d;
      mag1_q  <= mag_d;
      mult1_q <= mult_d;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod_d[c] = PROD_W'(mag1_q[c]) * PROD_W'(mult1_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      seg2_q  <= seg1_q;
      base2_q <= base1_q;
      prod2_q <= prod_d;
    end
  end

  // quotient estimate is exact or one low
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      scl[c]   = SCALE_W'(prod2_q[c]) * SCALE_W'(SEG_RECIP[seg2_q]);
      quo_d[c] = scl[c][RECIP_SHIFT +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      seg3_q  <= seg2_q;
      base3_q <= base2_q;
      quo3_q  <= quo_d;
      prod3_q <= prod2_q;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      back[c]  = PROD_W'(quo3_q[c]) * PROD_W'(SEG_SPAN[seg3_q]);
      rem_d[c] = REM_W'(prod3_q[c] - back[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      seg4_q  <= seg3_q;
      base4_q <= base3_q;
      quo4_q  <= quo3_q;
      rem4_q  <= rem_d;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_d[c] = CHAN_W'(base4_q[c] + quo4_q[c]
                + CHAN_W'(rem4_q[c] >= REM_W'(SEG_SPAN[seg4_q])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      chan5_q <= chan_d;
    end
  end

endmodule

// ----- rtl/core/spectrum_db_to_colormap.sv -----
// ----------------------------------------------------------------------------
// spectrum_db_to_colormap: spectrum bin level to RGB pixel
// Normalizes a dB level between floor and ceiling, shapes it with a 0.78
// power curve and interpolates among eight color stops.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// pixel per word, in order. The ratio divider produces one quotient bit per
// stage, ahead of the shaping ROM register and the interpolation stages.
// Every stage holds its own valid bit and fills bubbles while the output is
// stalled. Floor and ceiling must be written through the config port only
// while no word is in flight; the block itself does not enforce this.
module spectrum_db_to_colormap import sdbcm_pkg::*; #(
  parameter int unsigned ShapeTableBits = DEF_SHAPE_TABLE_BITS,
  parameter int unsigned RatioFracBits  = DEF_RATIO_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [LEVEL_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [LEVEL_W-1:0] level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CHAN_W-1:0]         red_o,
  output logic [CHAN_W-1:0]         green_o,
  output logic [CHAN_W-1:0]         blue_o
);

  localparam logic [ShapeTableBits:0] IdxFull = {1'b1, {ShapeTableBits{1'b0}}};

  logic signed [LEVEL_W-1:0] floor_q;
  logic signed [LEVEL_W-1:0] ceiling_q;

  logic                    rat_valid;
  logic                    rat_ready;
  logic [ShapeTableBits:0] rat_idx;
  logic                    shp_valid;
  logic                    shp_ready;
  logic [SHAPED_W-1:0]     shp_shaped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= FLOOR_RESET;
      ceiling_q <= CEILING_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FLOOR:   floor_q   <= cfg_wdata_i;
        REG_CEILING: ceiling_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sdbcm_ratio #(
    .ShapeTableBits (ShapeTableBits),
    .RatioFracBits  (RatioFracBits)
  ) u_ratio (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .floor_i     (floor_q),
    .ceiling_i   (ceiling_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .out_valid_o (rat_valid),
    .out_ready_i (rat_ready),
    .idx_o       (rat_idx)
  );

  sdbcm_shape #(
    .ShapeTableBits (ShapeTableBits)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rat_valid),
    .in_ready_o  (rat_ready),
    .idx_i       (rat_idx),
    .out_valid_o (shp_valid),
    .out_ready_i (shp_ready),
    .shaped_o    (shp_shaped)
  );

  sdbcm_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (shp_valid),
    .in_ready_o  (shp_ready),
    .shaped_i    (shp_shaped),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

`ifndef SYNTHESIS
  // a ready output lets every stage advance, so the input is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked although output is being drained");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with an empty output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rat_valid |-> (rat_idx <= IdxFull))
    else $error("shaping index beyond full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shp_valid |-> (shp_shaped <= SHAPED_ONE))
    else $error("shaped value beyond full scale");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the spectrum dB to colormap pipeline
// Drives bin levels under a range of floor/ceiling windows, predicts each
// pixel with an exact integer version of the shaping curve and the color
// stop interpolation, and compares every pixel that comes out, in order.
// ----------------------------------------------------------------------------
module tb_top import sdbcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHAPE_BITS   = DEF_SHAPE_TABLE_BITS;
  localparam int unsigned FRAC_BITS    = DEF_RATIO_FRAC_BITS;
  localparam int unsigned ROM_LAST     = 1 << SHAPE_BITS;
  localparam int unsigned Q16_ONE      = 65536;
  localparam int unsigned CURVE_NUM    = 39;
  localparam int unsigned CURVE_DEN    = 50;
  localparam int unsigned BIG_W        = 840;
  localparam int unsigned PIPE_LATENCY =
      ((FRAC_BITS < SHAPE_BITS) ? FRAC_BITS : SHAPE_BITS) + 8;
  localparam int unsigned RANDOM_WINDOWS = 12;
  localparam int unsigned WORDS_PER_WINDOW = 102;

  localparam logic signed [LEVEL_W-1:0] FLOOR_INIT = -16'sd30720;
  localparam logic signed [LEVEL_W-1:0] CEIL_INIT  = 16'sd0;

  localparam int STOP_AT [8] = '{0, 7864, 18350, 29491, 40632, 51118, 58982, 65536};
  localparam int STOP_COLOR [8][3] = '{
    '{2, 4, 10}, '{8, 18, 46}, '{22, 58, 124}, '{28, 142, 196},
    '{76, 208, 160}, '{244, 220, 72}, '{245, 128, 32}, '{250, 250, 250}
  };

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i   = REG_FLOOR;
  logic [LEVEL_W-1:0]        cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [LEVEL_W-1:0] level_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [CHAN_W-1:0]         red_o;
  logic [CHAN_W-1:0]         green_o;
  logic [CHAN_W-1:0]         blue_o;

  logic signed [LEVEL_W-1:0] pending_levels [$];
  pixel_t                    expected_pixels [$];
  int unsigned               shape_rom [ROM_LAST+1];

  logic signed [LEVEL_W-1:0] floor_cur = FLOOR_INIT;
  logic signed [LEVEL_W-1:0] ceil_cur  = CEIL_INIT;
  logic                      word_taken = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned pixels_seen  = 0;
  int unsigned windows_used = 1;

  spectrum_db_to_colormap DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit [BIG_W-1:0] big_pow(int unsigned base, int unsigned n);
    bit [BIG_W-1:0] acc;
    acc = 1;
    for (int k = 0; k < n; k++) acc = acc * BIG_W'(base);
    return acc;
  endfunction

  // largest y with y^50 <= i^39 * 2^(800 - 39*bits), i.e. (i/2^bits)^0.78 in Q16
  function automatic int unsigned curve_point(int unsigned idx);
    bit [BIG_W-1:0] target;
    int unsigned y;
    real guess;
    target = big_pow(idx, CURVE_NUM) << (CURVE_DEN * 16 - CURVE_NUM * SHAPE_BITS);
    guess = 65536.0 * ((real'(idx) / real'(ROM_LAST)) ** (real'(CURVE_NUM) / real'(CURVE_DEN)));
    y = $rtoi(guess);
    if (y > Q16_ONE) y = Q16_ONE;
    while (y < Q16_ONE && big_pow(y + 1, CURVE_DEN) <= target) y++;
    while (y > 0 && big_pow(y, CURVE_DEN) > target) y--;
    return y;
  endfunction

  function automatic pixel_t map_level_to_pixel(logic signed [LEVEL_W-1:0] lv,
                                                logic signed [LEVEL_W-1:0] fl,
                                                logic signed [LEVEL_W-1:0] cl);
    int diff;
    int span;
    longint unsigned ratio;
    longint unsigned idx;
    int shaped;
    int seg;
    longint lo_c;
    longint hi_c;
    longint delta;
    longint seg_len;
    longint q;
    int chan [3];
    pixel_t px;
    diff = int'(lv) - int'(fl);
    span = int'(cl) - int'(fl);
    if (span <= 0) ratio = (lv >= cl) ? (64'd1 << FRAC_BITS) : 64'd0;
    else if (diff <= 0) ratio = 0;
    else if (diff >= span) ratio = 64'd1 << FRAC_BITS;
    else ratio = (longint'(diff) << FRAC_BITS) / longint'(span);
    idx = (ratio << SHAPE_BITS) >> FRAC_BITS;
    if (idx > ROM_LAST) idx = ROM_LAST;
    shaped = int'(shape_rom[idx]);
    seg = 1;
    while (seg < 7 && shaped > STOP_AT[seg]) seg++;
    for (int c = 0; c < 3; c++) begin
      lo_c = STOP_COLOR[seg-1][c];
      hi_c = STOP_COLOR[seg][c];
      seg_len = STOP_AT[seg] - STOP_AT[seg-1];
      delta = (hi_c - lo_c) * longint'(shaped - STOP_AT[seg-1]);
      // floor division for falling channels
      q = (delta >= 0) ? delta / seg_len : -((-delta + seg_len - 1) / seg_len);
      chan[c] = int'(lo_c + q);
    end
    px.red   = CHAN_W'(chan[0]);
    px.green = CHAN_W'(chan[1]);
    px.blue  = CHAN_W'(chan[2]);
    return px;
  endfunction

  // most often near the window, some anywhere, some on its edges, some at the extremes
  function automatic logic signed [LEVEL_W-1:0] pick_level(int fl, int cl);
    int lo;
    int hi;
    int margin;
    int a;
    int b;
    int v;
    lo = (fl < cl) ? fl : cl;
    hi = (fl < cl) ? cl : fl;
    margin = (hi - lo) / 8 + 2;
    case ($urandom_range(9))
      0, 1, 2: v = int'($urandom_range(65535)) - 32768;
      3, 4, 5, 6: begin
        a = (lo - margin < -32768) ? -32768 : lo - margin;
        b = (hi + margin > 32767) ? 32767 : hi + margin;
        v = a + int'($urandom_range(b - a));
      end
      7, 8: begin
        v = ($urandom_range(1) == 0) ? lo : hi;
        v = v + int'($urandom_range(2)) - 1;
      end
      default: v = ($urandom_range(1) == 0) ? -32768 : 32767;
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return LEVEL_W'(v);
  endfunction

  // sender: bursts of words with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : sender
    logic nxt_valid;
    logic signed [LEVEL_W-1:0] nxt_level;
    nxt_valid = in_valid_i;
    nxt_level = level_i;
    if (in_valid_i && word_taken) nxt_valid = 1'b0;
    if (!nxt_valid && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_levels.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_level = pending_levels.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 1);
          case ($urandom_range(9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7, 8:    gap_left = $urandom_range(8, 1);
            default:       gap_left = $urandom_range(30, 9);
          endcase
        end else begin
          burst_left--;
        end
      end
    end
    in_valid_i <= nxt_valid;
    level_i    <= nxt_level;
  end

  // receiver: stall pattern switches between free flow, light, heavy and long stalls
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  always @(negedge clk_i) begin : receiver
    logic rdy;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(3);
      mode_left  = $urandom_range(200, 20);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(1) == 0);
      2:       rdy = ($urandom_range(3) == 0);
      default: rdy = ((mode_left % 32) == 0);
    endcase
    out_ready_i <= rdy;
  end

  always @(posedge clk_i) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      floor_cur  <= FLOOR_INIT;
      ceil_cur   <= CEIL_INIT;
      word_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FLOOR:   floor_cur <= cfg_wdata_i;
          REG_CEILING: ceil_cur  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
        end else begin
          want = expected_pixels.pop_front();
          if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       pixels_seen, want.red, want.green, want.blue,
                       red_o, green_o, blue_o);
          end
        end
      end
      word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        words_sent++;
        expected_pixels.push_back(map_level_to_pixel(level_i, floor_cur, ceil_cur));
      end
    end
  end

  task automatic drain_pipeline();
    while (pending_levels.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_window(int fl, int cl);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FLOOR;
    cfg_wdata_i <= LEVEL_W'(fl);
    @(negedge clk_i);
    cfg_idx_i   <= REG_CEILING;
    cfg_wdata_i <= LEVEL_W'(cl);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    windows_used++;
  endtask

  initial begin : stimulus
    int win_floor [RANDOM_WINDOWS];
    int win_ceil [RANDOM_WINDOWS];
    int a;
    int b;
    int j;
    for (int i = 0; i <= ROM_LAST; i++) shape_rom[i] = curve_point(i);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window: extremes, floor and ceiling edges, mid span
    pending_levels.push_back(-16'sd32768);
    pending_levels.push_back(16'sd32767);
    pending_levels.push_back(-16'sd30720);
    pending_levels.push_back(-16'sd30719);
    pending_levels.push_back(-16'sd30721);
    pending_levels.push_back(16'sd0);
    pending_levels.push_back(-16'sd1);
    pending_levels.push_back(16'sd1);
    pending_levels.push_back(-16'sd15360);

    // window of one table step per level: land just at or above and just below each stop
    set_window(0, ROM_LAST);
    for (int k = 1; k < 7; k++) begin
      j = 0;
      while (shape_rom[j] < STOP_AT[k]) j++;
      pending_levels.push_back(LEVEL_W'(j));
      if (j > 0) pending_levels.push_back(LEVEL_W'(j - 1));
    end

    // ceiling not above floor: step at the ceiling
    set_window(100, 100);
    pending_levels.push_back(16'sd99);
    pending_levels.push_back(16'sd100);
    pending_levels.push_back(16'sd101);
    set_window(32767, -32768);
    pending_levels.push_back(-16'sd32768);
    pending_levels.push_back(16'sd0);
    pending_levels.push_back(16'sd32767);

    win_floor = '{-32768, 0, -30720, 32767, -32768, 32767, 0, -1, 0, 0, 0, 0};
    win_ceil  = '{32767, ROM_LAST, 0, -32768, -32768, 32767, 1, 0, 0, 0, 0, 0};
    for (int w = 8; w < RANDOM_WINDOWS; w++) begin
      a = int'($urandom_range(65535)) - 32768;
      b = int'($urandom_range(65535)) - 32768;
      if (w == RANDOM_WINDOWS - 1 || a < b) begin
        win_floor[w] = a;
        win_ceil[w]  = b;
      end else begin
        win_floor[w] = b;
        win_ceil[w]  = a;
      end
    end

    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      set_window(win_floor[w], win_ceil[w]);
      for (int n = 0; n < WORDS_PER_WINDOW; n++)
        pending_levels.push_back(pick_level(win_floor[w], win_ceil[w]));
    end

    drain_pipeline();
    repeat (2 * PIPE_LATENCY + 4) @(posedge clk_i);
    if (expected_pixels.size() != 0) mismatches++;

    $display("%0d bin levels sent under %0d floor/ceiling windows", words_sent, windows_used);
    $display("%0d pixels compared, %0d wrong or unexpected", pixels_seen, mismatches);
    if (mismatches == 0) begin
      $display("spectrum_db_to_colormap: match");
    end else begin
      $display("spectrum_db_to_colormap: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("spectrum_db_to_colormap: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sdbcm_pkg.sv
rtl/core/sdbcm_ratio.sv
rtl/core/sdbcm_shape.sv
rtl/core/sdbcm_interp.sv
rtl/core/spectrum_db_to_colormap.sv
tb/tb_top.sv
